[rtl/multi_queue_ring_fifo_unit_macros.svh]
// assertion macros used by the ring fifo unit back end
`ifndef MULTI_QUEUE_RING_FIFO_UNIT_MACROS_SVH
`define MULTI_QUEUE_RING_FIFO_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define MQRF_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("mqrf assertion failed");
// condition must never be seen outside reset
`define MQRF_NEVER(name, clk, rstn, cond) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("mqrf forbidden condition seen");
`else
`define MQRF_ASSERT(name, clk, rstn, prop)
`define MQRF_NEVER(name, clk, rstn, cond)
`endif
`endif

[rtl/mqrf_pkg.sv]
// shared constants, types and codes of the multi queue ring fifo
package mqrf_pkg;

	localparam int NUM_QUEUES = 4;
	localparam int DEPTH = 16;

	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH);
	localparam int ADDR_W = QIDX_W + PTR_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam int WORD_W = 32;
	localparam int ACTION_W = 2;
	localparam int QSEL_W = 2;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W = 4;
	localparam int LOST_W = 32;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// decoded request as it travels from front to back
	typedef struct packed {
		logic                     is_init;
		logic                     is_write;
		logic                     is_read;
		logic                     q_ok;
		logic [QIDX_W-1:0]        q;
		logic signed [WORD_W-1:0] data;
	} cmd_t;

endpackage

[rtl/mqrf_front.sv]
// front end: takes requests and decodes them into commands
module mqrf_front import mqrf_pkg::*; (
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [ACTION_W-1:0]      action,
	input  logic [QSEL_W-1:0]        queue_index,
	input  logic signed [WORD_W-1:0] write_data,
	input  logic                     cmdq_full,
	output logic                     push,
	output cmd_t                     push_cmd
);

	action_t act;

	assign act = action_t'(action);
	assign req_ready = !cmdq_full;
	assign push = req_valid && !cmdq_full;

	always_comb begin
		push_cmd = '0;
		push_cmd.q_ok = 32'(queue_index) < NUM_QUEUES;
		push_cmd.q = QIDX_W'(queue_index);
		push_cmd.data = write_data;
		case (act)
			ACT_INIT: begin
				push_cmd.is_init = 1'b1;
			end
			ACT_WRITE: begin
				push_cmd.is_write = 1'b1;
			end
			ACT_READ: begin
				push_cmd.is_read = 1'b1;
			end
			ACT_QUERY: begin
				// no state change, report only
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/mqrf_cmd_fifo.sv]
// short command queue between front and back
module mqrf_cmd_fifo import mqrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t               entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;

	function automatic logic [CMDQ_AW-1:0] bump(input logic [CMDQ_AW-1:0] p);
		logic [CMDQ_AW-1:0] n;
		n = (p == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	assign full = count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH);
	assign empty = count_q == '0;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/mqrf_back.sv]
// back end: per queue pointers, shared word store and result register
`include "multi_queue_ring_fifo_unit_macros.svh"
module mqrf_back import mqrf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     head,
	input  logic                     empty,
	output logic                     pop,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [STATUS_W-1:0]      status,
	output logic signed [WORD_W-1:0] read_data,
	output logic [LEVEL_W-1:0]       fill_level,
	output logic [LOST_W-1:0]        lost_count
);

	logic [PTR_W-1:0]  rd_ptr_q [NUM_QUEUES];
	logic [PTR_W-1:0]  wr_ptr_q [NUM_QUEUES];
	logic [CNT_W-1:0]  fill_q   [NUM_QUEUES];
	logic [LOST_W-1:0] lost_q   [NUM_QUEUES];

	logic [WORD_W-1:0] store_q [STORE_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic              s1_valid_q;
	status_t           status_s1;
	logic              rd_ok_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [LOST_W-1:0] lost_s1;

	logic              advance;
	logic [QIDX_W-1:0] qi;
	logic [PTR_W-1:0]  rp_cur, rp_nxt, wp_cur, wp_nxt;
	logic [CNT_W-1:0]  fill_cur, fill_nxt;
	logic [LOST_W-1:0] lost_cur, lost_nxt;
	status_t           st;
	logic              rd_ok;
	logic              mem_we, mem_re;

	// pointers run over slots 0 .. DEPTH-2
	function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 2)) ? '0 : p + 1'b1;
		return n;
	endfunction

	assign advance = !s1_valid_q || rsp_ready;
	assign pop = !empty && advance;
	assign qi = head.q;

	always_comb begin
		rp_cur = rd_ptr_q[qi];
		wp_cur = wr_ptr_q[qi];
		fill_cur = fill_q[qi];
		lost_cur = lost_q[qi];
		rp_nxt = rp_cur;
		wp_nxt = wp_cur;
		fill_nxt = fill_cur;
		lost_nxt = lost_cur;
		st = ST_OK;
		rd_ok = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (head.q_ok) begin
			if (head.is_init) begin
				rp_nxt = '0;
				wp_nxt = '0;
				fill_nxt = '0;
				lost_nxt = '0;
			end else if (head.is_write) begin
				if (fill_cur == CNT_W'(DEPTH - 1)) begin
					lost_nxt = lost_cur + 1'b1;
					st = ST_FULL;
				end else begin
					mem_we = 1'b1;
					wp_nxt = step_ptr(wp_cur);
					fill_nxt = fill_cur + 1'b1;
				end
			end else if (head.is_read) begin
				if (fill_cur == '0) begin
					st = ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					rd_ok = 1'b1;
					rp_nxt = step_ptr(rp_cur);
					fill_nxt = fill_cur - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i] <= '0;
				lost_q[i] <= '0;
			end
			s1_valid_q <= 1'b0;
		end else begin
			if (pop && head.q_ok) begin
				rd_ptr_q[qi] <= rp_nxt;
				wr_ptr_q[qi] <= wp_nxt;
				fill_q[qi] <= fill_nxt;
				lost_q[qi] <= lost_nxt;
			end
			if (advance) begin
				s1_valid_q <= pop;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_s1 <= st;
			rd_ok_s1 <= rd_ok;
			level_s1 <= head.q_ok ? LEVEL_W'(fill_nxt) : '0;
			lost_s1 <= head.q_ok ? lost_nxt : '0;
		end
	end

	// shared word store, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (pop && mem_we) begin
			store_q[{qi, wp_cur}] <= head.data;
		end
		if (pop && mem_re) begin
			rdata_q <= store_q[{qi, rp_cur}];
		end
	end

	assign rsp_valid = s1_valid_q;
	assign status = status_s1;
	assign read_data = rd_ok_s1 ? rdata_q : '0;
	assign fill_level = level_s1;
	assign lost_count = lost_s1;

	`MQRF_ASSERT(a_full_at_cap, clk, arst_n, (s1_valid_q && status_s1 == ST_FULL) |-> (level_s1 == LEVEL_W'(DEPTH - 1)))
	`MQRF_ASSERT(a_empty_at_zero, clk, arst_n, (s1_valid_q && status_s1 == ST_EMPTY) |-> (level_s1 == '0))
	`MQRF_ASSERT(a_rdata_held, clk, arst_n, (s1_valid_q && !rsp_ready) |=> $stable(rdata_q))
	`MQRF_NEVER(a_pop_in_stall, clk, arst_n, pop && s1_valid_q && !rsp_ready)

endmodule

[rtl/multi_queue_ring_fifo_unit.sv]
// an accepted request is written into the command queue, then taken by the back end, and its result is registered
// throughput: one request per cycle while results are taken, set by the back end doing one queue access
// and one port of the shared word store each cycle
// a stalled result holds while up to two more requests wait in the command queue
// reset: every queue empty, all pointers and lost counters zero; no clearing pass
// top level of the multi queue ring fifo unit
module multi_queue_ring_fifo_unit import mqrf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [ACTION_W-1:0]      action,
	input  logic [QSEL_W-1:0]        queue_index,
	input  logic signed [WORD_W-1:0] write_data,
	// result channel
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [STATUS_W-1:0]      status,
	output logic signed [WORD_W-1:0] read_data,
	output logic [LEVEL_W-1:0]       fill_level,
	output logic [LOST_W-1:0]        lost_count
);

	// front to queue
	logic push;
	cmd_t push_cmd;
	logic cmdq_full;
	// queue to back
	logic pop;
	cmd_t head;
	logic cmdq_empty;

	// decode the request and check the queue number
	mqrf_front u_front (
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.queue_index (queue_index),
		.write_data  (write_data),
		.cmdq_full   (cmdq_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decouples request intake from a stalled result
	mqrf_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (cmdq_full),
		.pop      (pop),
		.head     (head),
		.empty    (cmdq_empty)
	);

	// queue state update, store access and result register
	mqrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (cmdq_empty),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.read_data  (read_data),
		.fill_level (fill_level),
		.lost_count (lost_count)
	);

endmodule

[bench/testbench.sv]
// self-checking bench for the multi queue ring fifo unit: directed and random requests
module testbench;
	import mqrf_pkg::*;

	// one expected response, field for field as the unit drives it
	typedef struct {
		status_t                  st;
		logic signed [WORD_W-1:0] word;
		logic [LEVEL_W-1:0]       level;
		logic [LOST_W-1:0]        lost;
	} fifo_result_t;

	// flavor of a stretch of random traffic: mostly writes, mostly reads, or even
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

	// cycles without any handshake before the run is declared hung
	localparam int IDLE_LIMIT = 1000;
	// settling time after the last response, before the final verdict
	localparam int SETTLE_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	logic [ACTION_W-1:0]      action = ACT_INIT;
	logic [QSEL_W-1:0]        queue_index = '0;
	logic signed [WORD_W-1:0] write_data = '0;

	// response channel
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] read_data;
	logic [LEVEL_W-1:0]       fill_level;
	logic [LOST_W-1:0]        lost_count;

	// shadow copy of every queue, updated when a request is accepted
	logic [WORD_W-1:0]  ring_words [NUM_QUEUES][DEPTH];
	logic [PTR_W-1:0]   head_ptr [NUM_QUEUES] = '{default: '0};
	logic [PTR_W-1:0]   tail_ptr [NUM_QUEUES] = '{default: '0};
	logic [LEVEL_W-1:0] held [NUM_QUEUES] = '{default: '0};
	logic [LOST_W-1:0]  dropped [NUM_QUEUES] = '{default: '0};

	// responses still owed by the unit, oldest first
	fifo_result_t pending_results[$];

	int errors = 0;
	int idle_cycles = 0;

	// sender burst shaping
	int burst_left = 0;
	bit sender_gaps = 1'b1;

	// receiver stall pattern, rotated every cycle and reshuffled now and then
	logic [15:0] stall_pattern = 16'hFFFF;
	int stall_period = 0;
	bit steady_ready = 1'b0;

	multi_queue_ring_fifo_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.queue_index(queue_index),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.read_data  (read_data),
		.fill_level (fill_level),
		.lost_count (lost_count)
	);

	always #6 clk = ~clk;

	// ring pointers run over slots 0 to DEPTH-2, one slot is never used
	function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
		return (int'(p) + 1 >= DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	// apply one request to the shadow queues and return what the unit must answer
	function automatic fifo_result_t apply_fifo_action(action_t act, logic [QSEL_W-1:0] q,
			logic signed [WORD_W-1:0] d);
		fifo_result_t r;
		r.st = ST_OK;
		r.word = '0;
		r.level = '0;
		r.lost = '0;
		// a queue number past the bank is ignored and answers all zero
		if (int'(q) >= NUM_QUEUES)
			return r;
		case (act)
		ACT_INIT: begin
			head_ptr[q] = '0;
			tail_ptr[q] = '0;
			held[q] = '0;
			dropped[q] = '0;
		end
		ACT_WRITE: begin
			if (int'(held[q]) >= DEPTH - 1) begin
				// full: the word is lost and the counter wraps upward
				dropped[q] = dropped[q] + 1'b1;
				r.st = ST_FULL;
			end else begin
				ring_words[q][tail_ptr[q]] = d;
				tail_ptr[q] = next_slot(tail_ptr[q]);
				held[q] = held[q] + 1'b1;
			end
		end
		ACT_READ: begin
			if (held[q] == 0) begin
				// empty: nothing moves
				r.st = ST_EMPTY;
			end else begin
				r.word = ring_words[q][head_ptr[q]];
				head_ptr[q] = next_slot(head_ptr[q]);
				held[q] = held[q] - 1'b1;
			end
		end
		default: ;
		endcase
		r.level = held[q];
		r.lost = dropped[q];
		return r;
	endfunction

	// drive one request at the falling edge, hold it until accepted, then predict
	task automatic send_request(action_t act, logic [QSEL_W-1:0] q,
			logic signed [WORD_W-1:0] d);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		action <= act;
		queue_index <= q;
		write_data <= d;
		do
			@(posedge clk);
		while (!req_ready);
		pending_results.push_back(apply_fifo_action(act, q, d));
	endtask

	// drop valid and hold off until every owed response has come back
	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// read of an empty queue and a query straight after reset
	task automatic test_empty_and_query();
		send_request(ACT_READ, 2'd2, 32'sh1234_5678);
		send_request(ACT_QUERY, 2'd1, -32'sd1);
	endtask

	// extreme words go in and the oldest come back out unchanged
	task automatic test_word_extremes();
		send_request(ACT_WRITE, 2'd0, 32'sh8000_0000);
		send_request(ACT_WRITE, 2'd0, 32'sh7FFF_FFFF);
		send_request(ACT_WRITE, 2'd0, -32'sd1);
		send_request(ACT_WRITE, 2'd0, 32'sd0);
		send_request(ACT_READ, 2'd0, 32'sd0);
		send_request(ACT_READ, 2'd0, 32'sd0);
	endtask

	// fill one queue to capacity, overflow it, then init wipes the lost count
	task automatic test_full_queue();
		for (int i = 0; i < DEPTH - 1; i++)
			send_request(ACT_WRITE, 2'd3, $urandom);
		send_request(ACT_WRITE, 2'd3, $urandom);
		send_request(ACT_INIT, 2'd3, $urandom);
	endtask

	// random traffic in phases that push queues toward full or toward empty
	task automatic test_random_traffic(int count);
		traffic_mix_t mix;
		action_t act;
		logic [QSEL_W-1:0] focus_q;
		logic [QSEL_W-1:0] q;
		logic signed [WORD_W-1:0] d;
		int pick;
		int write_cut;
		mix = MIX_EVEN;
		focus_q = '0;
		for (int i = 0; i < count; i++) begin
			if (i % 96 == 0) begin
				mix = traffic_mix_t'($urandom_range(0, 2));
				focus_q = QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
			end
			case (mix)
			MIX_FILL:  write_cut = 80;
			MIX_DRAIN: write_cut = 30;
			default:   write_cut = 55;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 2)
				act = ACT_INIT;
			else if (pick < 10)
				act = ACT_QUERY;
			else if (pick < write_cut)
				act = ACT_WRITE;
			else
				act = ACT_READ;
			// most requests of a phase go to one queue so it reaches full or empty
			q = ($urandom_range(0, 9) < 6) ? focus_q : QSEL_W'($urandom_range(0, 3));
			case ($urandom_range(0, 63))
			0:       d = 32'sh8000_0000;
			1:       d = 32'sh7FFF_FFFF;
			2:       d = -32'sd1;
			3:       d = 32'sd0;
			default: d = $urandom;
			endcase
			send_request(act, q, d);
		end
	endtask

	// no sender gaps and no receiver stalls: full rate for a while
	task automatic test_back_to_back(int count);
		sender_gaps = 1'b0;
		steady_ready = 1'b1;
		test_random_traffic(count);
		sender_gaps = 1'b1;
		steady_ready = 1'b0;
	endtask

	// receiver back pressure, changed at the falling edge
	always @(negedge clk) begin
		if (stall_period == 0) begin
			stall_period = $urandom_range(150, 250);
			case ($urandom_range(0, 3))
			0:       stall_pattern = 16'hFFFF;
			1:       stall_pattern = 16'h8000;
			default: stall_pattern = 16'($urandom);
			endcase
			if (stall_pattern == 0)
				stall_pattern = 16'h0101;
		end
		stall_period--;
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		rsp_ready <= stall_pattern[15] | steady_ready;
	end

	// compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		fifo_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: response with none expected, status %0d data %h level %0d lost %0d",
					$time, status, read_data, fill_level, lost_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					errors++;
				end
				if (read_data !== want.word) begin
					$display("%0t: read_data expected %h actual %h", $time, want.word, read_data);
					errors++;
				end
				if (fill_level !== want.level) begin
					$display("%0t: fill_level expected %0d actual %0d",
						$time, want.level, fill_level);
					errors++;
				end
				if (lost_count !== want.lost) begin
					$display("%0t: lost_count expected %0d actual %0d",
						$time, want.lost, lost_count);
					errors++;
				end
			end
		end
	end

	// hang detection: too long with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		test_empty_and_query();
		test_word_extremes();
		test_full_queue();
		// sender holds off until the scoreboard is empty
		wait_for_results();

		// random part
		test_random_traffic(700);
		test_back_to_back(250);
		wait_for_results();
		test_random_traffic(750);

		// drain and let the pipeline settle
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/mqrf_pkg.sv
rtl/mqrf_front.sv
rtl/mqrf_cmd_fifo.sv
rtl/mqrf_back.sv
rtl/multi_queue_ring_fifo_unit.sv
bench/testbench.sv
